### sv/occs_pkg.sv
package occs_pkg;

    // Trig unit sizing.
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int CW = 58;   // x and y datapath width
    localparam int ZW = 28;   // angle accumulator width, degrees Q16
    localparam int VW = 34;   // vectoring input width
    localparam int SCW = 34;  // sine and cosine result width, Q2.30
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int Q16_90 = 90 * 65536;
    localparam int Q16_180 = 180 * 65536;

    // Configuration register indexes.
    localparam logic [0:0] CFG_EYE_HEIGHT = 1'b0;
    localparam logic [0:0] CFG_DAMPING = 1'b1;

    typedef enum logic {
        CORDIC_ROTATE,
        CORDIC_VECTOR
    } cordic_mode_t;

    typedef enum logic {
        DS_DIVIDE,
        DS_SQRT
    } ds_mode_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_req_t;

    typedef struct packed {
        logic     start;
        ds_mode_t mode;
    } ds_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F_TURN,
        ST_F_YAW_GO,
        ST_F_YAW_WAIT,
        ST_F_PITCH_WAIT,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_MUL_TAKE,
        ST_S_LOAD,
        ST_S_YAW_WAIT,
        ST_S_DIV_WAIT,
        ST_S_SQRT_WAIT,
        ST_S_PITCH_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_HORIZ,
        OP_OFF_X,
        OP_OFF_Z,
        OP_LIFT,
        OP_ALPHA,
        OP_LERP_X,
        OP_LERP_Y,
        OP_LERP_Z,
        OP_SIN_SQ
    } op_t;

    // Arctangent of 2^-i in degrees, Q16.
    function automatic logic [21:0] atan_deg(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/occs_cordic.sv
module occs_cordic (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  occs_pkg::cordic_req_t                  req,
    input  logic signed [15:0]                     ang_in,
    input  logic signed [occs_pkg::VW-1:0]         vx_in,
    input  logic signed [occs_pkg::VW-1:0]         vy_in,
    output logic                                   done,
    output logic signed [occs_pkg::SCW-1:0]        sin_out,
    output logic signed [occs_pkg::SCW-1:0]        cos_out,
    output logic signed [occs_pkg::ZW-1:0]         ang_out
);
    import occs_pkg::*;

    localparam logic [4:0] LAST = 5'(CORDIC_ITERS - 1);
    localparam logic signed [ZW-1:0] Z90 = ZW'(Q16_90);
    localparam logic signed [ZW-1:0] Z180 = ZW'(Q16_180);

    logic                 busy_reg;
    logic                 done_reg;
    logic [4:0]           cnt_reg;
    cordic_mode_t         mode_reg;
    logic                 neg_reg;
    logic                 zero_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;

    logic signed [ZW-1:0] z_rot;
    logic signed [CW-1:0] vx_ext;
    logic signed [CW-1:0] vy_ext;
    logic signed [CW-1:0] xsh;
    logic signed [CW-1:0] ysh;
    logic signed [ZW-1:0] at;
    logic                 sel;
    logic signed [CW-1:0] xn;
    logic signed [CW-1:0] yn;

    // Seeds and one micro-rotation of the shared shift-add unit.
    always_comb begin
        z_rot = {{(ZW-25){ang_in[15]}}, ang_in, 9'b0};
        vx_ext = {{(CW-VW){vx_in[VW-1]}}, vx_in};
        vy_ext = {{(CW-VW){vy_in[VW-1]}}, vy_in};
        xsh = x_reg >>> cnt_reg;
        ysh = y_reg >>> cnt_reg;
        at = {{(ZW-22){1'b0}}, atan_deg(cnt_reg)};
        sel = (mode_reg == CORDIC_ROTATE) ? (z_reg >= 0) : !(y_reg > 0);
        xn = neg_reg ? -x_reg : x_reg;
        yn = neg_reg ? -y_reg : y_reg;
    end

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            mode_reg <= req.mode;
            if (req.mode == CORDIC_ROTATE) begin
                x_reg <= CW'(CORDIC_GAIN_Q30);
                y_reg <= '0;
                zero_reg <= 1'b0;
                if (z_rot > Z90) begin
                    z_reg <= z_rot - Z180;
                    neg_reg <= 1'b1;
                end else if (z_rot < -Z90) begin
                    z_reg <= z_rot + Z180;
                    neg_reg <= 1'b1;
                end else begin
                    z_reg <= z_rot;
                    neg_reg <= 1'b0;
                end
            end else begin
                neg_reg <= 1'b0;
                zero_reg <= (vx_in == '0) && (vy_in == '0);
                if (vx_in[VW-1]) begin
                    x_reg <= (-vx_ext) <<< 20;
                    y_reg <= (-vy_ext) <<< 20;
                    z_reg <= vy_in[VW-1] ? -Z180 : Z180;
                end else begin
                    x_reg <= vx_ext <<< 20;
                    y_reg <= vy_ext <<< 20;
                    z_reg <= '0;
                end
            end
        end else if (busy_reg) begin
            if (sel) begin
                x_reg <= x_reg - ysh;
                y_reg <= y_reg + xsh;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ysh;
                y_reg <= y_reg - xsh;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done = done_reg;
    assign sin_out = yn[SCW-1:0];
    assign cos_out = xn[SCW-1:0];
    assign ang_out = zero_reg ? '0 : z_reg;

endmodule

### sv/occs_divsqrt.sv
module occs_divsqrt (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  occs_pkg::ds_req_t    req,
    input  logic signed [56:0]   num_in,
    input  logic [13:0]          den_in,
    input  logic [60:0]          rad_in,
    output logic                 done,
    output logic signed [56:0]   quo_out,
    output logic [30:0]          root_out
);
    import occs_pkg::*;

    localparam logic [5:0] DIV_LAST = 6'd55;
    localparam logic [5:0] SQRT_LAST = 6'd31;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    ds_mode_t    mode_reg;
    logic        neg_reg;
    logic [13:0] den_reg;
    logic [14:0] rem_reg;
    logic [63:0] work_reg;
    logic [63:0] acc_reg;
    logic [63:0] bit_reg;

    logic [56:0] mag;
    logic [14:0] trial;
    logic [63:0] rb;
    logic [56:0] quo_pos;

    always_comb begin
        mag = num_in[56] ? 57'(-num_in) : 57'(num_in);
        trial = {rem_reg[13:0], work_reg[55]};
        rb = acc_reg + bit_reg;
        quo_pos = {1'b0, work_reg[55:0]};
    end

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == ((mode_reg == DS_DIVIDE) ? DIV_LAST : SQRT_LAST)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit or one root bit per cycle.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            mode_reg <= req.mode;
            neg_reg <= num_in[56];
            den_reg <= den_in;
            rem_reg <= '0;
            acc_reg <= '0;
            bit_reg <= 64'd1 << 62;
            if (req.mode == DS_DIVIDE) begin
                work_reg <= {8'b0, mag[55:0]};
            end else begin
                work_reg <= {3'b0, rad_in};
            end
        end else if (busy_reg) begin
            case (mode_reg)
                DS_DIVIDE: begin
                    if (trial >= {1'b0, den_reg}) begin
                        rem_reg <= trial - {1'b0, den_reg};
                        work_reg <= {work_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= trial;
                        work_reg <= {work_reg[62:0], 1'b0};
                    end
                end
                default: begin
                    if (work_reg >= rb) begin
                        work_reg <= work_reg - rb;
                        acc_reg <= (acc_reg >> 1) + bit_reg;
                    end else begin
                        acc_reg <= acc_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quo_out = neg_reg ? -quo_pos : quo_pos;
    assign root_out = acc_reg[30:0];

endmodule

### sv/orbit_chase_camera_step.sv
// Orbit chase camera, one follow update or one snap per transaction.
// Input channel s_*: s_tuser selects the action (0 follow, 1 snap); s_tdata
// carries the target, snap position, step time, key bits and wheel steps.
// Result channel m_*: every input transaction yields exactly one result with
// the eye position, look target, yaw, pitch and orbit distance after the step.
// Configuration channel cfg_*: index 0 writes eye_height, index 1 writes
// damping_rate; cfg_ready is always high and writes belong between
// transactions, while the block is idle.
// One item is worked at a time and s_tready is high only when the sequencer
// is idle. A follow update uses two rotation passes of the shared CORDIC unit
// and eight trips through the one registered multiplier. A snap uses two
// vectoring passes, a bit-serial divide, one multiplier trip and a bit-serial
// square root.
// The finished result sits in an output register; the next item is accepted
// while it waits, and a stalled receiver only holds the block when the next
// result is ready to be written. Reset restores the camera to eye (0, 2, 6),
// target zero, yaw 0, pitch -15 degrees, radius 6 and the default registers.
module orbit_chase_camera_step (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // target_x, target_y, target_z, snap_x, snap_y, snap_z, step_time,
    // key_bits, wheel_steps, zero fill
    input  logic [223:0] s_tdata,
    // action
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // eye_x, eye_y, eye_z, look_x, look_y, look_z, yaw_angle, pitch_angle,
    // orbit_distance, zero fill
    output logic [239:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import occs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Input item.
    logic signed [31:0]  tgt_reg [3];
    logic signed [31:0]  snp_reg [3];
    logic [15:0]         dt_reg;
    logic [3:0]          key_reg;
    logic signed [7:0]   whl_reg;

    // Camera state and configuration.
    logic signed [31:0]  eye_reg [3];
    logic signed [31:0]  look_reg [3];
    logic signed [15:0]  yaw_reg;
    logic signed [14:0]  pitch_reg;
    logic [13:0]         rad_reg;
    logic signed [31:0]  eh_reg;
    logic [15:0]         damp_reg;

    // Work registers.
    logic signed [SCW-1:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [23:0]  h_reg;
    logic signed [34:0]  des_reg [3];
    logic [16:0]         alpha_reg;
    logic signed [31:0]  s_reg;
    op_t                 op_reg;
    logic signed [35:0]  mul_a_reg, mul_a_next;
    logic signed [33:0]  mul_b_reg, mul_b_next;
    logic signed [69:0]  prod_reg;

    logic                out_valid_reg;
    logic [239:0]        out_data_reg;

    cordic_req_t         c_req;
    logic signed [15:0]  c_ang;
    logic signed [VW-1:0] c_vx, c_vy;
    logic                c_done;
    logic signed [SCW-1:0] c_sin, c_cos;
    logic signed [ZW-1:0] c_z;

    ds_req_t             d_req;
    logic signed [56:0]  d_num;
    logic [60:0]         d_rad;
    logic                d_done;
    logic signed [56:0]  d_quo;
    logic [30:0]         d_root;

    logic                in_take;
    logic                out_load;

    // Follow turn and zoom values.
    logic [18:0]         dt5;
    logic [18:0]         yaw_sum, pit_sum;
    logic signed [18:0]  dyaw, dpit;
    logic signed [18:0]  yw1, yw2, pt0, pt1, pt2, rr;
    logic signed [15:0]  yaw_turn;
    logic signed [14:0]  pitch_turn;
    logic [13:0]         rad_turn;
    logic signed [ZW-1:0] zr;
    logic signed [33:0]  dy_snap;
    logic signed [34:0]  dyeh;
    logic signed [69:0]  r22, r30, r16;
    logic signed [36:0]  esum;
    logic signed [31:0]  esat;
    logic [31:0]         prod_lo;

    function automatic logic signed [69:0] rnd_sh(input logic signed [69:0] v,
                                                  input logic [4:0] s);
        logic signed [69:0] half;
        half = 70'sd1 <<< (s - 5'd1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [15:0] wrap_yaw(input logic signed [18:0] y);
        logic signed [18:0] t;
        t = y;
        if (t >= 19'sd23040) t = t - 19'sd46080;
        if (t < -19'sd23040) t = t + 19'sd46080;
        return t[15:0];
    endfunction

    function automatic logic signed [18:0] clamp_pitch(input logic signed [18:0] p);
        logic signed [18:0] t;
        t = p;
        if (t > 19'sd11392) t = 19'sd11392;
        if (t < -19'sd11392) t = -19'sd11392;
        return t;
    endfunction

    assign in_take = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // Angle turn, pitch clamp and zoom for a follow update.
    always_comb begin
        dt5 = {1'b0, dt_reg, 2'b0} + {3'b0, dt_reg};
        yaw_sum = dt5 + 19'd16;
        pit_sum = dt5 + 19'd32;
        dyaw = {5'b0, yaw_sum[18:5]};
        dpit = {6'b0, pit_sum[18:6]};
        yw1 = {{3{yaw_reg[15]}}, yaw_reg};
        if (key_reg[0]) yw1 = yw1 - dyaw;
        yw2 = yw1;
        if (key_reg[1]) yw2 = yw2 + dyaw;
        yaw_turn = wrap_yaw(yw2);
        pt0 = {{4{pitch_reg[14]}}, pitch_reg};
        pt1 = key_reg[2] ? clamp_pitch(pt0 + dpit) : pt0;
        pt2 = key_reg[3] ? clamp_pitch(pt1 - dpit) : pt1;
        pitch_turn = pt2[14:0];
        rr = {5'b0, rad_reg} - ({{11{whl_reg[7]}}, whl_reg} <<< 7);
        if (rr < 19'sd256) rr = 19'sd256;
        if (rr > 19'sd12800) rr = 19'sd12800;
        rad_turn = (whl_reg != 8'sd0) ? rr[13:0] : rad_reg;
    end

    // Rounding of the shared multiplier and trig results.
    always_comb begin
        zr = (c_z + ZW'(256)) >>> 9;
        r22 = rnd_sh(prod_reg, 5'd22);
        r30 = rnd_sh(prod_reg, 5'd30);
        r16 = rnd_sh(prod_reg, 5'd16);
        prod_lo = prod_reg[31:0];
        dy_snap = {{2{snp_reg[1][31]}}, snp_reg[1]} - {{2{tgt_reg[1][31]}}, tgt_reg[1]};
        dyeh = {dy_snap[33], dy_snap} - {{3{eh_reg[31]}}, eh_reg};
        case (op_reg)
            OP_LERP_X: esum = {{5{eye_reg[0][31]}}, eye_reg[0]} + {r16[35], r16[35:0]};
            OP_LERP_Y: esum = {{5{eye_reg[1][31]}}, eye_reg[1]} + {r16[35], r16[35:0]};
            default:   esum = {{5{eye_reg[2][31]}}, eye_reg[2]} + {r16[35], r16[35:0]};
        endcase
        if (esum > 37'sd2147483647) esat = 32'sh7fffffff;
        else if (esum < -37'sd2147483648) esat = 32'sh80000000;
        else esat = esum[31:0];
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a_next = '0;
        mul_b_next = '0;
        case (op_reg)
            OP_HORIZ: begin
                mul_a_next = {22'b0, rad_reg};
                mul_b_next = cp_reg;
            end
            OP_OFF_X: begin
                mul_a_next = {{12{h_reg[23]}}, h_reg};
                mul_b_next = sy_reg;
            end
            OP_OFF_Z: begin
                mul_a_next = {{12{h_reg[23]}}, h_reg};
                mul_b_next = cy_reg;
            end
            OP_LIFT: begin
                mul_a_next = {22'b0, rad_reg};
                mul_b_next = sp_reg;
            end
            OP_ALPHA: begin
                mul_a_next = {20'b0, dt_reg};
                mul_b_next = {18'b0, damp_reg};
            end
            OP_LERP_X: begin
                mul_a_next = {des_reg[0][34], des_reg[0]} - {{4{eye_reg[0][31]}}, eye_reg[0]};
                mul_b_next = {17'b0, alpha_reg};
            end
            OP_LERP_Y: begin
                mul_a_next = {des_reg[1][34], des_reg[1]} - {{4{eye_reg[1][31]}}, eye_reg[1]};
                mul_b_next = {17'b0, alpha_reg};
            end
            OP_LERP_Z: begin
                mul_a_next = {des_reg[2][34], des_reg[2]} - {{4{eye_reg[2][31]}}, eye_reg[2]};
                mul_b_next = {17'b0, alpha_reg};
            end
            OP_SIN_SQ: begin
                mul_a_next = {{4{s_reg[31]}}, s_reg};
                mul_b_next = {{2{s_reg[31]}}, s_reg};
            end
            default: begin
                mul_a_next = '0;
                mul_b_next = '0;
            end
        endcase
    end

    // Sequencer: next state and unit starts.
    always_comb begin
        state_next = state_reg;
        c_req = '{start: 1'b0, mode: CORDIC_ROTATE};
        d_req = '{start: 1'b0, mode: DS_DIVIDE};
        c_ang = yaw_reg;
        c_vx = {{(VW-32){1'b0}}, 1'b0, d_root};
        c_vy = {{(VW-32){s_reg[31]}}, s_reg};
        d_num = {dyeh, 22'b0};
        d_rad = (61'd1 << 60) - prod_reg[60:0];
        if (state_reg == ST_F_YAW_WAIT) begin
            c_ang = {pitch_reg[14], pitch_reg};
        end
        if (state_reg == ST_S_LOAD) begin
            c_vx = {{2{snp_reg[2][31]}}, snp_reg[2]} - {{2{tgt_reg[2][31]}}, tgt_reg[2]};
            c_vy = {{2{tgt_reg[0][31]}}, tgt_reg[0]} - {{2{snp_reg[0][31]}}, snp_reg[0]};
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = s_tuser[0] ? ST_S_LOAD : ST_F_TURN;
            end
            ST_F_TURN: state_next = ST_F_YAW_GO;
            ST_F_YAW_GO: begin
                c_req = '{start: 1'b1, mode: CORDIC_ROTATE};
                state_next = ST_F_YAW_WAIT;
            end
            ST_F_YAW_WAIT: begin
                if (c_done) begin
                    c_req = '{start: 1'b1, mode: CORDIC_ROTATE};
                    state_next = ST_F_PITCH_WAIT;
                end
            end
            ST_F_PITCH_WAIT: begin
                if (c_done) state_next = ST_MUL_ISSUE;
            end
            ST_MUL_ISSUE: state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: state_next = ST_MUL_TAKE;
            ST_MUL_TAKE: begin
                if (op_reg == OP_LERP_Z) begin
                    state_next = ST_OUT;
                end else if (op_reg == OP_SIN_SQ) begin
                    d_req = '{start: 1'b1, mode: DS_SQRT};
                    state_next = ST_S_SQRT_WAIT;
                end else begin
                    state_next = ST_MUL_ISSUE;
                end
            end
            ST_S_LOAD: begin
                c_req = '{start: 1'b1, mode: CORDIC_VECTOR};
                state_next = ST_S_YAW_WAIT;
            end
            ST_S_YAW_WAIT: begin
                if (c_done) begin
                    d_req = '{start: 1'b1, mode: DS_DIVIDE};
                    state_next = ST_S_DIV_WAIT;
                end
            end
            ST_S_DIV_WAIT: begin
                if (d_done) state_next = ST_MUL_ISSUE;
            end
            ST_S_SQRT_WAIT: begin
                if (d_done) begin
                    c_req = '{start: 1'b1, mode: CORDIC_VECTOR};
                    state_next = ST_S_PITCH_WAIT;
                end
            end
            ST_S_PITCH_WAIT: begin
                if (c_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, camera state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            eye_reg[0] <= 32'sd0;
            eye_reg[1] <= 32'sd131072;
            eye_reg[2] <= 32'sd393216;
            look_reg[0] <= 32'sd0;
            look_reg[1] <= 32'sd0;
            look_reg[2] <= 32'sd0;
            yaw_reg <= 16'sd0;
            pitch_reg <= -15'sd1920;
            rad_reg <= 14'd1536;
            eh_reg <= 32'sd98304;
            damp_reg <= 16'd1536;
        end else begin
            state_reg <= state_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_EYE_HEIGHT: eh_reg <= cfg_data;
                    CFG_DAMPING:    damp_reg <= cfg_data[15:0];
                    default:        eh_reg <= eh_reg;
                endcase
            end
            case (state_reg)
                ST_F_TURN: begin
                    yaw_reg <= yaw_turn;
                    pitch_reg <= pitch_turn;
                    rad_reg <= rad_turn;
                    look_reg <= tgt_reg;
                end
                ST_MUL_TAKE: begin
                    case (op_reg)
                        OP_LERP_X: eye_reg[0] <= esat;
                        OP_LERP_Y: eye_reg[1] <= esat;
                        OP_LERP_Z: eye_reg[2] <= esat;
                        default:   eye_reg[0] <= eye_reg[0];
                    endcase
                end
                ST_S_LOAD: begin
                    eye_reg <= snp_reg;
                    look_reg <= tgt_reg;
                end
                ST_S_YAW_WAIT: begin
                    if (c_done) yaw_reg <= wrap_yaw(zr[18:0]);
                end
                ST_S_PITCH_WAIT: begin
                    if (c_done) pitch_reg <= zr[14:0];
                end
                default: begin
                    yaw_reg <= yaw_reg;
                end
            endcase
        end
    end

    // Item capture, work registers and the shared multiplier.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a_reg * mul_b_reg;
        if (in_take) begin
            tgt_reg[0] <= s_tdata[31:0];
            tgt_reg[1] <= s_tdata[63:32];
            tgt_reg[2] <= s_tdata[95:64];
            snp_reg[0] <= s_tdata[127:96];
            snp_reg[1] <= s_tdata[159:128];
            snp_reg[2] <= s_tdata[191:160];
            dt_reg <= s_tdata[207:192];
            key_reg <= s_tdata[211:208];
            whl_reg <= s_tdata[219:212];
        end
        if (out_load) begin
            out_data_reg <= {3'b0, rad_reg, pitch_reg, yaw_reg, look_reg[2], look_reg[1],
                             look_reg[0], eye_reg[2], eye_reg[1], eye_reg[0]};
        end
        case (state_reg)
            ST_F_YAW_WAIT: begin
                if (c_done) begin
                    sy_reg <= c_sin;
                    cy_reg <= c_cos;
                end
            end
            ST_F_PITCH_WAIT: begin
                if (c_done) begin
                    sp_reg <= c_sin;
                    cp_reg <= c_cos;
                    op_reg <= OP_HORIZ;
                end
            end
            ST_MUL_ISSUE: begin
                mul_a_reg <= mul_a_next;
                mul_b_reg <= mul_b_next;
            end
            ST_MUL_TAKE: begin
                case (op_reg)
                    OP_HORIZ: begin
                        h_reg <= r22[23:0];
                        op_reg <= OP_OFF_X;
                    end
                    OP_OFF_X: begin
                        des_reg[0] <= {{3{tgt_reg[0][31]}}, tgt_reg[0]} - r30[34:0];
                        op_reg <= OP_OFF_Z;
                    end
                    OP_OFF_Z: begin
                        des_reg[2] <= {{3{tgt_reg[2][31]}}, tgt_reg[2]} + r30[34:0];
                        op_reg <= OP_LIFT;
                    end
                    OP_LIFT: begin
                        des_reg[1] <= {{3{tgt_reg[1][31]}}, tgt_reg[1]} + r22[34:0]
                                      + {{3{eh_reg[31]}}, eh_reg};
                        op_reg <= OP_ALPHA;
                    end
                    OP_ALPHA: begin
                        if (prod_lo > 32'd16777216) alpha_reg <= 17'd65536;
                        else alpha_reg <= prod_lo[24:8];
                        op_reg <= OP_LERP_X;
                    end
                    OP_LERP_X: op_reg <= OP_LERP_Y;
                    OP_LERP_Y: op_reg <= OP_LERP_Z;
                    default:   op_reg <= op_reg;
                endcase
            end
            ST_S_DIV_WAIT: begin
                if (d_done) begin
                    if (d_quo > 57'sd1073741824) s_reg <= 32'sd1073741824;
                    else if (d_quo < -57'sd1073741824) s_reg <= -32'sd1073741824;
                    else s_reg <= d_quo[31:0];
                    op_reg <= OP_SIN_SQ;
                end
            end
            default: begin
                h_reg <= h_reg;
            end
        endcase
    end

    occs_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (c_req),
        .ang_in  (c_ang),
        .vx_in   (c_vx),
        .vy_in   (c_vy),
        .done    (c_done),
        .sin_out (c_sin),
        .cos_out (c_cos),
        .ang_out (c_z)
    );

    occs_divsqrt u_divsqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (d_req),
        .num_in   (d_num),
        .den_in   (rad_reg),
        .rad_in   (d_rad),
        .done     (d_done),
        .quo_out  (d_quo),
        .root_out (d_root)
    );

endmodule

### sv/occs_checker.sv
module occs_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [223:0] s_tdata,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [239:0] m_tdata,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [0:0]   cfg_index,
    input logic [31:0]  cfg_data
);

    // A transaction starts a multi-cycle job, so the next one cannot follow at once.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two consecutive cycles");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The orbit distance stays within its clamp.
    a_distance_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[236:223] >= 14'd256 && m_tdata[236:223] <= 14'd12800)
        else $error("orbit distance out of range");

    // Pitch stays within a right angle and yaw stays wrapped.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[222:208]) >= -15'sd11520
            && $signed(m_tdata[222:208]) <= 15'sd11520
            && $signed(m_tdata[207:192]) <= 16'sd23039)
        else $error("angle out of range");

    // Reset leaves no result pending and the input open.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the block");

endmodule

bind orbit_chase_camera_step occs_checker u_occs_checker (.*);

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import occs_pkg::*;

    localparam int LIMIT_CYCLES = 900000;
    localparam int LATENCY_CYCLES = 200;
    localparam int ATAN_LEN = 24;
    localparam int ROT_STEPS = 16;

    // One camera input item.
    typedef struct {
        logic        snap;
        logic [31:0] tgt [3];
        logic [31:0] pos [3];
        logic [15:0] dt;
        logic [3:0]  keys;
        logic [7:0]  wheel;
    } cam_cmd_t;

    // One camera result item.
    typedef struct packed {
        logic [13:0] radius;
        logic [14:0] pitch;
        logic [15:0] yaw;
        logic [31:0] lz;
        logic [31:0] ly;
        logic [31:0] lx;
        logic [31:0] ez;
        logic [31:0] ey;
        logic [31:0] ex;
    } cam_view_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [239:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [31:0]  cfg_data;

    orbit_chase_camera_step i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Camera state as tracked by the predictor.
    longint cam_eye [3];
    longint cam_look [3];
    longint cam_yaw;
    longint cam_pitch;
    longint cam_radius;
    longint lift_height;
    longint damping;

    cam_view_t expected_views [$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off_cycles;
    longint    cycle_count;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint wrap_deg(longint y);
        if (y >= 23040) y -= 46080;
        if (y < -23040) y += 46080;
        return y;
    endfunction

    function automatic longint arc_step(int i);
        longint arcs [ATAN_LEN] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
            4, 2, 1, 0};
        return arcs[i];
    endfunction

    // Rotation CORDIC: sine and cosine Q2.30 of an angle in degrees Q9.7.
    task automatic rotate_unit(input longint ang, output longint sn, output longint cs);
        longint z, x, y, xs, ys;
        bit flip;
        z = ang * 512;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 90 * 65536) begin
            z -= 180 * 65536;
            flip = 1;
        end else if (z < -90 * 65536) begin
            z += 180 * 65536;
            flip = 1;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= arc_step(i);
            end else begin
                x += ys;
                y -= xs;
                z += arc_step(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endtask

    // Vectoring CORDIC: angle of (x, y) in degrees Q16.
    function automatic longint heading_q16(longint y, longint x);
        longint base, z, xs, ys;
        base = 0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            base = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        x = x * (longint'(1) <<< 20);
        y = y * (longint'(1) <<< 20);
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += arc_step(i);
            end else begin
                x -= ys;
                y += xs;
                z -= arc_step(i);
            end
        end
        return base + z;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // Advance the camera by one item and queue the view it produces.
    task automatic camera_advance(input cam_cmd_t c);
        longint tg [3], sp [3], des [3];
        longint dt, wheel, dy, s, co, num, dyaw, dp, yw, pt, sy, cy, sq, cq, h, prod;
        longint alpha, e;
        cam_view_t v;
        dt = c.dt;
        wheel = longint'($signed(c.wheel));
        for (int i = 0; i < 3; i++) begin
            tg[i] = longint'($signed(c.tgt[i]));
            sp[i] = longint'($signed(c.pos[i]));
        end
        if (c.snap) begin
            for (int i = 0; i < 3; i++) begin
                cam_eye[i] = sp[i];
                cam_look[i] = tg[i];
            end
            cam_yaw = wrap_deg(round_shift(heading_q16(-(sp[0] - tg[0]), sp[2] - tg[2]), 9));
            dy = sp[1] - tg[1];
            num = (dy - lift_height) * (longint'(1) <<< 22);
            s = clip(num / cam_radius, -(longint'(1) <<< 30), longint'(1) <<< 30);
            co = int_sqrt((64'd1 << 60) - longint'(s * s));
            cam_pitch = round_shift(heading_q16(s, co), 9);
        end else begin
            dyaw = (5 * dt + 16) >>> 5;
            dp = (5 * dt + 32) >>> 6;
            yw = cam_yaw;
            pt = cam_pitch;
            if (c.keys[0]) yw -= dyaw;
            if (c.keys[1]) yw += dyaw;
            cam_yaw = wrap_deg(yw);
            if (c.keys[2]) pt = clip(pt + dp, -11392, 11392);
            if (c.keys[3]) pt = clip(pt - dp, -11392, 11392);
            cam_pitch = pt;
            if (wheel != 0) cam_radius = clip(cam_radius - wheel * 128, 256, 12800);
            rotate_unit(cam_yaw, sy, cy);
            rotate_unit(cam_pitch, sq, cq);
            h = round_shift(cam_radius * cq, 22);
            des[0] = tg[0] - round_shift(h * sy, 30);
            des[1] = tg[1] + round_shift(cam_radius * sq, 22) + lift_height;
            des[2] = tg[2] + round_shift(h * cy, 30);
            prod = dt * damping;
            if (prod > (longint'(1) <<< 24)) prod = longint'(1) <<< 24;
            alpha = prod >>> 8;
            for (int i = 0; i < 3; i++) begin
                e = cam_eye[i] + round_shift((des[i] - cam_eye[i]) * alpha, 16);
                cam_eye[i] = clip(e, -64'sd2147483648, 64'sd2147483647);
                cam_look[i] = tg[i];
            end
        end
        v.ex = cam_eye[0][31:0];
        v.ey = cam_eye[1][31:0];
        v.ez = cam_eye[2][31:0];
        v.lx = cam_look[0][31:0];
        v.ly = cam_look[1][31:0];
        v.lz = cam_look[2][31:0];
        v.yaw = cam_yaw[15:0];
        v.pitch = cam_pitch[14:0];
        v.radius = cam_radius[13:0];
        expected_views.push_back(v);
    endtask

    task automatic report_field(input string name, input longint unsigned want,
                                input longint unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Compare each result transaction with the oldest expected view.
    always @(posedge aclk) begin
        cam_view_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[236:0];
            if (expected_views.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("mismatch: unexpected result %h", got);
            end else begin
                want = expected_views.pop_front();
                report_field("eye_x", want.ex, got.ex);
                report_field("eye_y", want.ey, got.ey);
                report_field("eye_z", want.ez, got.ez);
                report_field("look_x", want.lx, got.lx);
                report_field("look_y", want.ly, got.ly);
                report_field("look_z", want.lz, got.lz);
                report_field("yaw_angle", want.yaw, got.yaw);
                report_field("pitch_angle", want.pitch, got.pitch);
                report_field("orbit_distance", want.radius, got.radius);
            end
        end
    end

    // Receiver: random stalls plus one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Offer one input transaction, idling at random before it.
    task automatic send_item(input cam_cmd_t c);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_tdata <= {4'd0, c.wheel, c.keys, c.dt, c.pos[2], c.pos[1], c.pos[0],
                    c.tgt[2], c.tgt[1], c.tgt[0]};
        s_tuser <= c.snap;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        camera_advance(c);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_views();
        while (expected_views.size() != 0) @(posedge aclk);
        repeat (LATENCY_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_EYE_HEIGHT) lift_height = longint'($signed(val));
        else damping = val[15:0];
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
            default: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
        endcase
    endfunction

    function automatic cam_cmd_t random_cmd();
        cam_cmd_t c;
        c.snap = ($urandom_range(99) < 25);
        for (int i = 0; i < 3; i++) begin
            c.tgt[i] = rand_coord();
            c.pos[i] = rand_coord();
        end
        c.dt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
        c.keys = $urandom_range(15);
        c.wheel = ($urandom_range(2) == 0) ? 8'($urandom) : 8'(int'($urandom_range(6)) - 3);
        if (c.snap && $urandom_range(9) == 0) c.pos = c.tgt;
        return c;
    endfunction

    function automatic cam_cmd_t make_cmd(logic snap, logic [31:0] t, logic [31:0] p,
                                          logic [15:0] dt, logic [3:0] keys,
                                          logic [7:0] wheel);
        cam_cmd_t c;
        c.snap = snap;
        c.tgt = '{t, t, t};
        c.pos = '{p, p, p};
        c.dt = dt;
        c.keys = keys;
        c.wheel = wheel;
        return c;
    endfunction

    // Main sequence: reset, directed table, configured random phases.
    initial begin
        cam_cmd_t directed [$];
        cam_cmd_t c;
        cam_view_t first_view;
        logic [31:0] heights [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0001_8000};
        logic [31:0] rates [4] = '{32'h0000_FFFF, 32'h0000_0000, 32'h0000_0100, 32'h0000_0600};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cam_eye = '{0, 131072, 393216};
        cam_look = '{0, 0, 0};
        cam_yaw = 0;
        cam_pitch = -1920;
        cam_radius = 1536;
        lift_height = 98304;
        damping = 1536;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero step time right after reset: eye stays at its reset place.
        c = make_cmd(1'b0, 32'h0, 32'h0, 16'h0, 4'h0, 8'h0);
        send_item(c);
        first_view = '{radius: 14'd1536, pitch: -15'sd1920, yaw: 16'd0, lz: 0, ly: 0,
                       lx: 0, ez: 32'd393216, ey: 32'd131072, ex: 32'd0};
        if (expected_views[$] != first_view) begin
            mismatch_count++;
            $display("mismatch: predictor reset view %h", expected_views[$]);
        end
        // Extremes, key combinations, wheel limits, far targets, snap corners.
        directed.push_back(make_cmd(1'b0, 32'h0, 32'h0, 16'hFFFF, 4'b0001, 8'h80));
        directed.push_back(make_cmd(1'b0, 32'h0, 32'h0, 16'hFFFF, 4'b0010, 8'h7F));
        directed.push_back(make_cmd(1'b0, 32'h0, 32'h0, 16'hFFFF, 4'b0011, 8'h01));
        directed.push_back(make_cmd(1'b0, 32'h0, 32'h0, 16'hFFFF, 4'b0100, 8'hFF));
        directed.push_back(make_cmd(1'b0, 32'h0, 32'h0, 16'hFFFF, 4'b0100, 8'h00));
        directed.push_back(make_cmd(1'b0, 32'h0, 32'h0, 16'hFFFF, 4'b1000, 8'h00));
        directed.push_back(make_cmd(1'b0, 32'h0, 32'h0, 16'hFFFF, 4'b1100, 8'h00));
        directed.push_back(make_cmd(1'b0, 32'h0, 32'h0, 16'hFFFF, 4'b1111, 8'h00));
        directed.push_back(make_cmd(1'b0, 32'h7FFF_FFFF, 32'h0, 16'hFFFF, 4'b0000, 8'h00));
        directed.push_back(make_cmd(1'b0, 32'h8000_0000, 32'h0, 16'hFFFF, 4'b0000, 8'h00));
        directed.push_back(make_cmd(1'b0, 32'h0001_0000, 32'h0, 16'h0001, 4'b0000, 8'h00));
        directed.push_back(make_cmd(1'b1, 32'h0, 32'h0, 16'h0, 4'h0, 8'h0));
        directed.push_back(make_cmd(1'b1, 32'h0, 32'h7FFF_FFFF, 16'hFFFF, 4'hF, 8'h7F));
        directed.push_back(make_cmd(1'b1, 32'h0, 32'h8000_0000, 16'h0, 4'h0, 8'h80));
        directed.push_back(make_cmd(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 4'h0, 8'h0));
        c = make_cmd(1'b1, 32'h0, 32'h0, 16'h0, 4'h0, 8'h0);
        c.pos[0] = 32'h0;
        c.pos[1] = 32'h0001_8000;
        c.pos[2] = 32'hFFFF_0000;
        directed.push_back(c);
        c.pos[0] = 32'hFFFF_FFFF;
        directed.push_back(c);
        // Yaw pushed round to +180 degrees so that it wraps.
        directed.push_back(make_cmd(1'b0, 32'h0, 32'h0, 16'd36864, 4'b0010, 8'h00));
        directed.push_back(make_cmd(1'b0, 32'h0, 32'h0, 16'd36864, 4'b0010, 8'h00));
        foreach (directed[i]) send_item(directed[i]);
        drain_views();

        // Random phases across register settings and idling patterns.
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(CFG_EYE_HEIGHT, heights[phase]);
            write_reg(CFG_DAMPING, rates[phase]);
            send_idle_pct = (phase == 0) ? 30 : (phase == 1 ? 63 : 0);
            recv_idle_pct = (phase == 0) ? 63 : (phase == 1 ? 30 : 0);
            if (phase == 2) hold_off_cycles = 2000;
            for (int n = 0; n < 210; n++) send_item(random_cmd());
            drain_views();
        end

        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
